### rtl/dps_pkg.sv
// package: types, coefficient table and arithmetic helpers for the ode step block
`default_nettype none
package dps_pkg;
  localparam int unsigned MaxSteps = 1024;
  localparam int unsigned FracBits = 20;
  localparam int unsigned CoefBits = 28;
  localparam int unsigned CntW = 11;
  localparam int unsigned DataW = 32;

  localparam logic [1:0] RegXStart = 2'd0;
  localparam logic [1:0] RegYStart = 2'd1;
  localparam logic [1:0] RegStep = 2'd2;
  localparam logic [1:0] RegCount = 2'd3;

  // tableau entries with 28 fraction bits, rounded half away from zero
  localparam longint CqScale = 64'sd536870912;
  localparam longint CN0 = (1 * CqScale + 5) / (2 * 5);
  localparam longint CN1 = (3 * CqScale + 10) / (2 * 10);
  localparam longint CN2 = (4 * CqScale + 5) / (2 * 5);
  localparam longint CN3 = (8 * CqScale + 9) / (2 * 9);
  localparam longint COne = (1 * CqScale + 1) / (2 * 1);
  localparam longint CA10 = (3 * CqScale + 40) / (2 * 40);
  localparam longint CA11 = (9 * CqScale + 40) / (2 * 40);
  localparam longint CA20 = (44 * CqScale + 45) / (2 * 45);
  localparam longint CA21 = (-56 * CqScale - 15) / (2 * 15);
  localparam longint CA22 = (32 * CqScale + 9) / (2 * 9);
  localparam longint CA30 = (19372 * CqScale + 6561) / (2 * 6561);
  localparam longint CA31 = (-25360 * CqScale - 2187) / (2 * 2187);
  localparam longint CA32 = (64448 * CqScale + 6561) / (2 * 6561);
  localparam longint CA33 = (-212 * CqScale - 729) / (2 * 729);
  localparam longint CA40 = (9017 * CqScale + 3168) / (2 * 3168);
  localparam longint CA41 = (-355 * CqScale - 33) / (2 * 33);
  localparam longint CA42 = (46732 * CqScale + 5247) / (2 * 5247);
  localparam longint CA43 = (49 * CqScale + 176) / (2 * 176);
  localparam longint CA44 = (-5103 * CqScale - 18656) / (2 * 18656);
  localparam longint CA50 = (35 * CqScale + 384) / (2 * 384);
  localparam longint CA52 = (500 * CqScale + 1113) / (2 * 1113);
  localparam longint CA53 = (125 * CqScale + 192) / (2 * 192);
  localparam longint CA54 = (-2187 * CqScale - 6784) / (2 * 6784);
  localparam longint CA55 = (11 * CqScale + 84) / (2 * 84);
  localparam longint CE0 = (71 * CqScale + 57600) / (2 * 57600);
  localparam longint CE2 = (-71 * CqScale - 16695) / (2 * 16695);
  localparam longint CE3 = (71 * CqScale + 1920) / (2 * 1920);
  localparam longint CE4 = (-17253 * CqScale - 339200) / (2 * 339200);
  localparam longint CE5 = (22 * CqScale + 525) / (2 * 525);
  localparam longint CE6 = (-1 * CqScale - 40) / (2 * 40);

  // multiplier operand select
  typedef enum logic [1:0] {
    OP_COEF = 2'd0,
    OP_XX = 2'd1,
    OP_HF = 2'd2,
    OP_IDX = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_XSTART, S_XN, S_XX, S_HF, S_KST, S_AC, S_AY, S_EC, S_EO, S_OUT
  } state_e;

  typedef struct packed {
    logic       load_start;
    logic       x_base;
    logic       x_node;
    logic       mul_xx;
    logic       mul_hf;
    logic       k_store;
    logic       acc_clear;
    logic       acc_coef;
    logic       y_stage;
    logic       err_clear;
    logic       err_coef;
    logic       commit;
    logic       out_load;
    logic       reject;
    logic [2:0] stage;
    logic [2:0] tap;
  } cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    if (v > 80'sd2147483647) return 32'sh7fffffff;
    if (v < -80'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [79:0] rshift(input logic signed [79:0] p,
                                               input int unsigned s);
    logic signed [79:0] half;
    logic signed [79:0] mag;
    half = 80'sd1 <<< (s - 1);
    if (p >= 0) return (p + half) >>> s;
    mag = (-p + half) >>> s;
    return -mag;
  endfunction

  // a(stage,tap) for stages 0..5, node c(stage) when tap==7, e(tap) when stage==7
  function automatic logic signed [33:0] coef(input logic [2:0] s, input logic [2:0] j);
    longint c;
    c = 0;
    unique case ({s, j})
      {3'd0, 3'd7}: c = CN0;
      {3'd1, 3'd7}: c = CN1;
      {3'd2, 3'd7}: c = CN2;
      {3'd3, 3'd7}: c = CN3;
      {3'd4, 3'd7}: c = COne;
      {3'd5, 3'd7}: c = COne;
      {3'd0, 3'd0}: c = CN0;
      {3'd1, 3'd0}: c = CA10;
      {3'd1, 3'd1}: c = CA11;
      {3'd2, 3'd0}: c = CA20;
      {3'd2, 3'd1}: c = CA21;
      {3'd2, 3'd2}: c = CA22;
      {3'd3, 3'd0}: c = CA30;
      {3'd3, 3'd1}: c = CA31;
      {3'd3, 3'd2}: c = CA32;
      {3'd3, 3'd3}: c = CA33;
      {3'd4, 3'd0}: c = CA40;
      {3'd4, 3'd1}: c = CA41;
      {3'd4, 3'd2}: c = CA42;
      {3'd4, 3'd3}: c = CA43;
      {3'd4, 3'd4}: c = CA44;
      {3'd5, 3'd0}: c = CA50;
      {3'd5, 3'd2}: c = CA52;
      {3'd5, 3'd3}: c = CA53;
      {3'd5, 3'd4}: c = CA54;
      {3'd5, 3'd5}: c = CA55;
      {3'd7, 3'd0}: c = CE0;
      {3'd7, 3'd2}: c = CE2;
      {3'd7, 3'd3}: c = CE3;
      {3'd7, 3'd4}: c = CE4;
      {3'd7, 3'd5}: c = CE5;
      {3'd7, 3'd6}: c = CE6;
      default: c = 0;
    endcase
    return 34'(c);
  endfunction
endpackage
`default_nettype wire

### rtl/dps_ctrl.sv
// controller: sequences the stages, taps and result of one step
`default_nettype none
module dps_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          restart_i,
  input  wire logic          done_i,
  input  wire logic          out_free_i,
  output dps_pkg::cmd_t      cmd_o,
  output logic               busy_o
);
  dps_pkg::state_e state_q, state_d;
  logic [2:0] stage_q, stage_d, tap_q, tap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dps_pkg::S_IDLE;
      stage_q <= '0;
      tap_q <= '0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      tap_q <= tap_d;
    end
  end

  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    tap_d = tap_q;
    unique case (state_q)
      dps_pkg::S_IDLE: begin
        if (start_i) begin
          if (restart_i || done_i) state_d = dps_pkg::S_OUT;
          else state_d = dps_pkg::S_XSTART;
          stage_d = 3'd6;
        end
      end
      dps_pkg::S_XSTART: state_d = dps_pkg::S_XX;
      dps_pkg::S_XN: state_d = dps_pkg::S_XX;
      dps_pkg::S_XX: state_d = dps_pkg::S_HF;
      dps_pkg::S_HF: state_d = dps_pkg::S_KST;
      dps_pkg::S_KST: begin
        if (stage_q == 3'd5) begin
          state_d = dps_pkg::S_EC;
          tap_d = '0;
        end else begin
          stage_d = (stage_q == 3'd6) ? 3'd0 : stage_q + 3'd1;
          tap_d = '0;
          state_d = dps_pkg::S_AC;
        end
      end
      dps_pkg::S_AC: begin
        if (tap_q == stage_q) state_d = dps_pkg::S_AY;
        else tap_d = tap_q + 3'd1;
      end
      dps_pkg::S_AY: state_d = dps_pkg::S_XN;
      dps_pkg::S_EC: begin
        if (tap_q == 3'd6) state_d = dps_pkg::S_EO;
        else tap_d = tap_q + 3'd1;
      end
      dps_pkg::S_EO: state_d = dps_pkg::S_OUT;
      dps_pkg::S_OUT: if (out_free_i) state_d = dps_pkg::S_IDLE;
      default: state_d = dps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.stage = stage_q;
    cmd_o.tap = tap_q;
    busy_o = (state_q != dps_pkg::S_IDLE);
    unique case (state_q)
      dps_pkg::S_IDLE: begin
        cmd_o.load_start = start_i && restart_i;
        cmd_o.reject = start_i && !restart_i && done_i;
        cmd_o.x_base = start_i;
        cmd_o.acc_clear = start_i;
        cmd_o.err_clear = start_i;
      end
      dps_pkg::S_XSTART: ;
      dps_pkg::S_XN: cmd_o.x_node = 1'b1;
      dps_pkg::S_XX: cmd_o.mul_xx = 1'b1;
      dps_pkg::S_HF: cmd_o.mul_hf = 1'b1;
      dps_pkg::S_KST: begin
        cmd_o.k_store = 1'b1;
        cmd_o.acc_clear = 1'b1;
      end
      dps_pkg::S_AC: cmd_o.acc_coef = 1'b1;
      dps_pkg::S_AY: cmd_o.y_stage = 1'b1;
      dps_pkg::S_EC: cmd_o.err_coef = 1'b1;
      dps_pkg::S_EO: cmd_o.commit = 1'b1;
      dps_pkg::S_OUT: cmd_o.out_load = out_free_i;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### rtl/dps_datapath.sv
// datapath: stage registers, k store, shared multiplier and accumulators
`default_nettype none
module dps_datapath #(
  parameter int unsigned FRAC_BITS = dps_pkg::FracBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  dps_pkg::cmd_t           cmd_i,
  input  wire logic signed [31:0] x_start_i,
  input  wire logic signed [31:0] y_start_i,
  input  wire logic signed [31:0] h_i,
  input  wire logic [10:0]        count_i,
  input  wire logic [10:0]        limit_i,
  output logic                    done_o,
  output logic [10:0]             idx_o,
  output logic signed [31:0]      x_o,
  output logic signed [31:0]      y_o,
  output logic signed [31:0]      err_o,
  output logic                    last_o,
  output logic                    rej_o
);
  logic signed [31:0] y_q, xt_q, xs_q, ys_q, kn_q;
  logic signed [63:0] xx_q;
  logic signed [31:0] k_q [7];
  logic signed [79:0] acc_q, err_q;
  logic [10:0] idx_q;
  logic rej_q;
  logic signed [31:0] ma;
  logic signed [33:0] mb;
  logic signed [79:0] prod;
  logic signed [79:0] fv;
  logic [10:0] idx_nxt;
  logic [2:0] kidx;

  assign done_o = (idx_q >= limit_i);
  assign idx_nxt = cmd_i.commit ? idx_q + 11'd1 : idx_q;
  assign kidx = (cmd_i.stage == 3'd6) ? 3'd0 : cmd_i.stage + 3'd1;

  always_comb begin
    fv = 80'(xx_q) - 80'(xs_q) * 3 - (80'sd1 <<< FRAC_BITS) - 80'(ys_q);
    ma = h_i;
    mb = dps_pkg::coef(cmd_i.stage, 3'd7);
    if (cmd_i.mul_xx) begin
      ma = xs_q;
      mb = 34'(xs_q);
    end else if (cmd_i.mul_hf) begin
      ma = h_i;
      mb = 34'(dps_pkg::sat32(fv));
    end else if (cmd_i.acc_coef) begin
      ma = k_q[cmd_i.tap];
      mb = dps_pkg::coef(cmd_i.stage, cmd_i.tap);
    end else if (cmd_i.err_coef) begin
      ma = k_q[cmd_i.tap];
      mb = dps_pkg::coef(3'd7, cmd_i.tap);
    end
    prod = 80'(ma) * 80'(mb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q <= 32'sd576717;
      idx_q <= '0;
      rej_q <= 1'b0;
    end else begin
      if (cmd_i.load_start) begin
        y_q <= y_start_i;
        idx_q <= '0;
      end
      if (cmd_i.x_base) rej_q <= cmd_i.reject;
      if (cmd_i.commit) begin
        y_q <= ys_q;
        idx_q <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.x_base) begin
      xt_q <= dps_pkg::sat32(80'(x_start_i) + 80'(signed'({1'b0, idx_q})) * 80'(h_i));
      xs_q <= dps_pkg::sat32(80'(x_start_i) + 80'(signed'({1'b0, idx_q})) * 80'(h_i));
      ys_q <= y_q;
    end
    if (cmd_i.x_node)
      xs_q <= dps_pkg::sat32(80'(xt_q) + dps_pkg::rshift(prod, dps_pkg::CoefBits));
    if (cmd_i.mul_xx) xx_q <= 64'(dps_pkg::rshift(prod, FRAC_BITS));
    if (cmd_i.mul_hf) kn_q <= dps_pkg::sat32(dps_pkg::rshift(prod, FRAC_BITS));
    if (cmd_i.k_store) k_q[kidx] <= kn_q;
    if (cmd_i.acc_clear) acc_q <= 80'(y_q);
    if (cmd_i.acc_coef) acc_q <= acc_q + dps_pkg::rshift(prod, dps_pkg::CoefBits);
    if (cmd_i.y_stage) ys_q <= dps_pkg::sat32(acc_q);
    if (cmd_i.err_clear) err_q <= '0;
    if (cmd_i.err_coef) err_q <= err_q + dps_pkg::rshift(prod, dps_pkg::CoefBits);
    if (cmd_i.out_load) begin
      idx_o <= idx_q;
      x_o <= dps_pkg::sat32(80'(x_start_i) + 80'(signed'({1'b0, idx_q})) * 80'(h_i));
      y_o <= y_q;
      err_o <= rej_q ? '0 : dps_pkg::sat32(err_q);
      last_o <= (idx_q == count_i);
      rej_o <= rej_q;
    end
  end
endmodule
`default_nettype wire

### rtl/dormand_prince_ode_step_top.sv
// top level: streaming ode step integrator with apb configuration
//  channel | dir | fields
//  s_axis  | in  | tdata[0] restart
//  m_axis  | out | tdata idx, x, y, err; tlast last_step; tuser rejected
//  apb     | in  | x_start, y_start, step_size, step_count
// a step runs on the one shared multiplier: k0, then each stage s in turn, then
//   7 error taps, plus start, wait, commit and output states
// the result is registered into the output fields in the output state
// a restart or rejected tick goes from idle straight to the output state
// reset restores register defaults, including y_start, sets step_count to 50 and clears the step index
// a stalled result holds the next step's result in the output state, and the input after it
`default_nettype none
module dormand_prince_ode_step_top #(
  parameter int unsigned FRAC_BITS = dps_pkg::FracBits
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // restart
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [111:0]      m_axis_tdata,   // step_index, x, y, error
  output logic              m_axis_tlast,
  output logic              m_axis_tuser,   // rejected
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  logic signed [31:0] xs_q, ys_q, h_q;
  logic [10:0] cnt_q, lim;
  logic vld_q, busy, done, start;
  dps_pkg::cmd_t cmd;
  logic [10:0] idx;
  logic signed [31:0] x, y, e;
  logic lst, rj;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xs_q <= 32'sd1048576;
      ys_q <= 32'sd576717;
      h_q <= 32'sd20972;
      cnt_q <= 11'd50;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        dps_pkg::RegXStart: xs_q <= pwdata;
        dps_pkg::RegYStart: ys_q <= pwdata;
        dps_pkg::RegStep: h_q <= pwdata;
        dps_pkg::RegCount: cnt_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      dps_pkg::RegXStart: prdata = xs_q;
      dps_pkg::RegYStart: prdata = ys_q;
      dps_pkg::RegStep: prdata = h_q;
      dps_pkg::RegCount: prdata = {21'd0, cnt_q};
      default: prdata = '0;
    endcase
  end
  assign lim = (cnt_q > 11'(dps_pkg::MaxSteps)) ? 11'(dps_pkg::MaxSteps) : cnt_q;

  assign s_axis_tready = !busy;
  assign start = s_axis_tvalid && s_axis_tready;

  dps_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .restart_i(s_axis_tdata[0]), .done_i(done),
    .out_free_i(!vld_q || m_axis_tready), .cmd_o(cmd), .busy_o(busy)
  );
  dps_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .x_start_i(xs_q), .y_start_i(ys_q), .h_i(h_q),
    .count_i(cnt_q), .limit_i(lim), .done_o(done), .idx_o(idx), .x_o(x), .y_o(y),
    .err_o(e), .last_o(lst), .rej_o(rj)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (cmd.out_load) vld_q <= 1'b1;
    else if (m_axis_tready) vld_q <= 1'b0;
  end
  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata = {5'd0, e, y, x, idx};
  assign m_axis_tlast = lst;
  assign m_axis_tuser = rj;
endmodule
`default_nettype wire

### rtl/dps_checker.sv
// checker: port-level assertions bound to the top level
`default_nettype none
module dps_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [111:0] m_axis_tdata,
  input wire logic m_axis_tlast,
  input wire logic m_axis_tuser
);
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
      $stable({m_axis_tuser, m_axis_tlast, m_axis_tdata}))
    else $error("result dropped");
  a_rej_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[106:75] == 32'd0)
    else $error("rejected with error");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted while busy");
endmodule
bind dormand_prince_ode_step_top dps_checker u_chk (.*);
`default_nettype wire
